// File: design/firdf_pkg.sv
package firdf_pkg;

  // Sample, coefficient, product, tap index and fraction widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned FRAC_W   = 15;

  // Request operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // operands on the inputs are valid this cycle
  } mac_ctrl_t;

endpackage

// File: design/firdf_mac.sv
module firdf_mac import firdf_pkg::*; #(
  parameter int unsigned ACC_W = 42
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] coef_i,
  input  logic signed [SAMPLE_W-1:0] samp_i,
  output logic signed [ACC_W-1:0]    acc_o,
  output logic                       busy_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Register the product ahead of the adder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= coef_i * samp_i;
    end
  end

  // Accumulate one product per cycle, clear at the start of a sample
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

// File: design/fir_filter_direct_form.sv
// Direct-form FIR filter, TAPS taps, 16-bit signed samples, Q1.15 coefficients.
// A load request (operation 1) writes one coefficient; a tap_index of TAPS or
// more is dropped. A filter request (operation 0) pushes the sample into a
// circular delay line and runs one multiply-accumulate per tap through a
// single shared 16x16 multiplier before the result is registered; in_ready_o
// is low meanwhile. The result is the sum shifted right by 15, truncated
// toward zero and saturated to 16 bits, with saturated_o marking a clipped
// result. The output register lets the next request be taken while a result
// waits for out_ready_i. After reset a clearing pass zeroes both memories
// before the first request.
module fir_filter_direct_form import firdf_pkg::*; #(
  parameter int unsigned TAPS = 320
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [INDEX_W-1:0]         tap_index_i,
  input  logic signed [SAMPLE_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] filtered_o,
  output logic                       saturated_o
);

  localparam int unsigned AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam int unsigned IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int unsigned ACC_W = PROD_W + 1 + $clog2(TAPS);
  localparam int unsigned TW    = ACC_W - FRAC_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     head_q, head_d, head_new;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic              rd_vld_q;
  logic              issue;
  logic              in_acc, smp_acc, load_acc;
  logic [IW-1:0]     tap_ext;
  logic              load_ok;

  logic                       dly_we, coef_we;
  logic [AW-1:0]              dly_waddr, coef_waddr;
  logic signed [SAMPLE_W-1:0] dly_wdata, coef_wdata;
  logic signed [SAMPLE_W-1:0] dly_mem  [TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly_rdata_q, coef_rdata_q;

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [TW-1:0]    trunc_q;
  logic                    sat;
  logic signed [SAMPLE_W-1:0] sat_val;

  logic                       out_vld_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                       saturated_q;

  // Decode the incoming request
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign smp_acc    = in_acc && (operation_i == OP_FILTER);
  assign load_acc   = in_acc && (operation_i == OP_LOAD);
  assign tap_ext    = IW'(tap_index_i);
  assign load_ok    = tap_ext < IW'(TAPS);

  // Newest sample goes one slot below the current head
  assign head_new = (head_q == '0) ? AW'(TAPS - 1) : head_q - AW'(1);

  assign issue = (state_q == ST_MAC) && (cnt_q != CNT_W'(TAPS));

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    rd_ptr_d = rd_ptr_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TAPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (smp_acc) begin
          state_d  = ST_MAC;
          head_d   = head_new;
          rd_ptr_d = head_new;
          cnt_d    = '0;
        end
      end
      ST_MAC: begin
        if (issue) begin
          cnt_d    = cnt_q + CNT_W'(1);
          rd_ptr_d = (rd_ptr_q == AW'(TAPS - 1)) ? '0 : rd_ptr_q + AW'(1);
        end else if (!rd_vld_q && !mac_busy) begin
          state_d = ST_TRUNC;
        end
      end
      ST_TRUNC: begin
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      head_q   <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= issue;
    end
  end

  // Memory write ports: clearing pass, new sample, coefficient load
  assign dly_we     = (state_q == ST_CLEAR) || smp_acc;
  assign dly_waddr  = (state_q == ST_CLEAR) ? cnt_q[AW-1:0] : head_new;
  assign dly_wdata  = (state_q == ST_CLEAR) ? '0 : value_i;
  assign coef_we    = (state_q == ST_CLEAR) || (load_acc && load_ok);
  assign coef_waddr = (state_q == ST_CLEAR) ? cnt_q[AW-1:0] : tap_ext[AW-1:0];
  assign coef_wdata = (state_q == ST_CLEAR) ? '0 : value_i;

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    dly_rdata_q <= dly_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata_q <= coef_mem[cnt_q[AW-1:0]];
  end

  // Shared multiply-accumulate unit
  assign mac_ctrl.clr = smp_acc;
  assign mac_ctrl.vld = rd_vld_q;

  firdf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rdata_q),
    .samp_i (dly_rdata_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // Truncate toward zero: bias negative sums before the shift
  assign acc_adj = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TRUNC) begin
      trunc_q <= acc_adj[ACC_W-1:FRAC_W];
    end
  end

  // Saturate to 16 bits when the upper bits are not a sign extension
  assign sat = !((&trunc_q[TW-1:SAMPLE_W-1]) || !(|trunc_q[TW-1:SAMPLE_W-1]));
  assign sat_val = trunc_q[TW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_W-1){1'b1}}};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == ST_SAT) && (!out_vld_q || out_ready_i)) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SAT) && (!out_vld_q || out_ready_i)) begin
      filtered_q  <= sat ? sat_val : trunc_q[SAMPLE_W-1:0];
      saturated_q <= sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TAPS))
    else $error("tap counter beyond tap count");

  a_smp_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (state_q == ST_MAC) && (cnt_q == '0))
    else $error("sample request did not start the tap sweep");

  a_load_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> $stable(head_q) && (state_q == ST_IDLE))
    else $error("coefficient load disturbed the delay line");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRUNC) |-> !mac_busy && !rd_vld_q)
    else $error("result taken before the accumulator drained");

endmodule

// File: tb/tb_fir_filter_direct_form.sv
`timescale 1ns / 100ps

import firdf_pkg::*;

localparam int unsigned FIR_TAPS    = 320;
localparam int unsigned CYCLE_LIMIT = 3_000_000;

typedef struct packed {
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;
} fir_result_t;

// Track coefficients and sample history, and queue the filter outputs they imply
class fir_scoreboard;
  logic signed [SAMPLE_W-1:0] coeff_q   [FIR_TAPS];
  logic signed [SAMPLE_W-1:0] history_q [FIR_TAPS];
  fir_result_t                expected_q [$];
  int mismatches;
  int results_seen;
  int clipped_seen;
  int filters_seen;
  int loads_seen;
  int dropped_loads;

  function new();
    foreach (coeff_q[n]) begin
      coeff_q[n]   = '0;
      history_q[n] = '0;
    end
    mismatches    = 0;
    results_seen  = 0;
    clipped_seen  = 0;
    filters_seen  = 0;
    loads_seen    = 0;
    dropped_loads = 0;
  endfunction

  // Apply one accepted request and queue the output it causes, if any
  function void note_request(logic op, logic [INDEX_W-1:0] idx,
                             logic signed [SAMPLE_W-1:0] val);
    longint      sum;
    longint      q;
    fir_result_t res;
    if (op == OP_LOAD) begin
      loads_seen++;
      if (idx < FIR_TAPS) coeff_q[idx] = val;
      else dropped_loads++;
      return;
    end
    filters_seen++;
    // Advance the delay line, newest sample at position zero
    for (int n = FIR_TAPS - 1; n > 0; n--) history_q[n] = history_q[n-1];
    history_q[0] = val;
    sum = 0;
    for (int n = 0; n < FIR_TAPS; n++) sum += longint'(coeff_q[n]) * longint'(history_q[n]);
    // Scale by 2^-15 with truncation toward zero
    if (sum < 0) q = -((-sum) >>> FRAC_W);
    else q = sum >>> FRAC_W;
    res.saturated = 1'b0;
    if (q > 32767) begin
      q = 32767;
      res.saturated = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      res.saturated = 1'b1;
    end
    res.filtered = q[SAMPLE_W-1:0];
    expected_q.push_back(res);
  endfunction

  // Compare one accepted output with the oldest pending one
  function void check_result(logic signed [SAMPLE_W-1:0] filtered, logic saturated);
    fir_result_t want;
    results_seen++;
    if (saturated === 1'b1) clipped_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output: filtered %0d saturated %0b, nothing pending",
                 filtered, saturated);
      return;
    end
    want = expected_q.pop_front();
    if (filtered !== want.filtered || saturated !== want.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on output %0d: filtered exp %0d got %0d, saturated exp %0b got %0b",
                 results_seen, want.filtered, filtered, want.saturated, saturated);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_fir_filter_direct_form;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = OP_FILTER;
  logic [INDEX_W-1:0]         tap_index_i = '0;
  logic signed [SAMPLE_W-1:0] value_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_o;
  logic                       saturated_o;

  fir_scoreboard sb = new();

  int          cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned coeff_span     = 32768;
  int unsigned coeff_zero_pct = 0;

  fir_filter_direct_form #(.TAPS(FIR_TAPS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .tap_index_i (tap_index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o),
    .saturated_o (saturated_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall the output at random, check accepted outputs, guard against hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(filtered_o, saturated_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs still pending", cycle_count,
               sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request after an optional idle gap and hold it until taken
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                              input logic signed [SAMPLE_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    tap_index_i <= idx;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, idx, val);
  endtask

  // Hold off new requests until every pending output has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_in_span(int unsigned span);
    int v;
    v = int'($urandom_range(2 * span - 1)) - int'(span);
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_edge();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return rand_in_span(32768);
    if (roll < 90) return rand_in_span(256);
    return pick_edge();
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_coeff();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < coeff_zero_pct) return '0;
    if (roll < coeff_zero_pct + 5) return pick_edge();
    return rand_in_span(coeff_span);
  endfunction

  // Mix filter requests with coefficient loads, a few of them out of range
  task automatic random_mix(input int count);
    logic [INDEX_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45) begin
        send_request(OP_FILTER, INDEX_W'($urandom_range(511)), pick_sample());
      end else begin
        if ($urandom_range(9) == 0) idx = INDEX_W'($urandom_range(511, FIR_TAPS));
        else idx = INDEX_W'($urandom_range(FIR_TAPS - 1));
        send_request(OP_LOAD, idx, pick_coeff());
      end
      if ($urandom_range(49) == 0) drain_results();
    end
  endtask

  // Boundary values, rounding toward zero, clipping both ways, dropped loads
  task automatic directed_checks();
    send_request(OP_FILTER, 9'd0,   16'sd1234);
    send_request(OP_LOAD,   9'd0,   16'sh8000);
    send_request(OP_FILTER, 9'd0,   16'sh8000);
    send_request(OP_FILTER, 9'd511, 16'sh7FFF);
    send_request(OP_LOAD,   9'd0,   16'sh7FFF);
    send_request(OP_LOAD,   9'd319, 16'sh8000);
    send_request(OP_LOAD,   9'd320, 16'sh7FFF);
    send_request(OP_LOAD,   9'd511, 16'shFFFF);
    send_request(OP_LOAD,   9'd341, 16'sh5555);
    send_request(OP_FILTER, 9'd0,   16'sh8000);
    send_request(OP_LOAD,   9'd0,   16'shFFFF);
    send_request(OP_LOAD,   9'd1,   16'sd0);
    send_request(OP_FILTER, 9'd0,   16'sd1);
    send_request(OP_FILTER, 9'd0,   16'shFFFF);
    send_request(OP_LOAD,   9'd1,   16'sh7FFF);
    send_request(OP_LOAD,   9'd2,   16'sh7FFF);
    send_request(OP_LOAD,   9'd3,   16'sh7FFF);
    send_request(OP_LOAD,   9'd170, 16'shAAAA);
    send_request(OP_FILTER, 9'd0,   16'sh8000);
    send_request(OP_FILTER, 9'd0,   16'sh8000);
    send_request(OP_FILTER, 9'd0,   16'sh8000);
    send_request(OP_FILTER, 9'd0,   16'sh7FFF);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_checks();
    drain_results();

    // Light sender gaps, heavy output stalls, small coefficients
    send_idle_pct  = 12;
    recv_idle_pct  = 73;
    coeff_span     = 256;
    coeff_zero_pct = 20;
    random_mix(450);
    drain_results();

    // Heavy sender gaps, light output stalls, full-range coefficients
    send_idle_pct  = 73;
    recv_idle_pct  = 12;
    coeff_span     = 32768;
    coeff_zero_pct = 10;
    random_mix(450);
    drain_results();

    // Reprogram every tap with sparse small coefficients, then run without gaps
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    coeff_span     = 64;
    coeff_zero_pct = 50;
    for (int t = 0; t < FIR_TAPS; t++) send_request(OP_LOAD, INDEX_W'(t), pick_coeff());
    random_mix(250);
    drain_results();

    repeat (FIR_TAPS + 20) @(posedge clk_i);

    $display("covered %0d filter requests and %0d coefficient loads (%0d outside the taps)",
             sb.filters_seen, sb.loads_seen, sb.dropped_loads);
    $display("checked %0d outputs, %0d clipped, %0d mismatches, %0d left pending",
             sb.results_seen, sb.clipped_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
